[hdl/mme_pkg.sv]
// Shared constants, codes and types of the matrix multiply engine.
package mme_pkg;

  localparam int MAX_DIM_DEFAULT = 8;

  localparam int CFG_W       = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int OPCODE_W    = 2;
  localparam int COORD_W     = 3;
  localparam int DATA_W      = 16;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int ACC_W       = 40;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 48;

  localparam logic [OPCODE_W-1:0] OP_LOAD_A  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_LOAD_B  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

  localparam logic [CFG_W-1:0] ROWS_A_RESET    = 4'd2;
  localparam logic [CFG_W-1:0] INNER_DIM_RESET = 4'd3;
  localparam logic [CFG_W-1:0] COLS_B_RESET    = 4'd2;

  // Control that travels with each multiply step down the pipeline.
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               first;
    logic               last;
    logic               zero;
    logic               last_elem;
  } step_ctrl_t;

  // Store write request decoded from a load transaction.
  typedef struct packed {
    logic               we_a;
    logic               we_b;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [DATA_W-1:0]  data;
  } load_req_t;

endpackage

[hdl/mme_store.sv]
// Operand stores for matrices A and B with registered read ports.
module mme_store import mme_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic                                     clk,
  input  load_req_t                                load_req,
  input  logic                                     rd_en,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]       rd_addr_a,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]       rd_addr_b,
  output logic [DATA_W-1:0]                        rd_data_a,
  output logic [DATA_W-1:0]                        rd_data_b
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = $clog2(MAX_DIM);

  logic [DATA_W-1:0] mem_a [DEPTH];
  logic [DATA_W-1:0] mem_b [DEPTH];
  logic [ADDR_W-1:0] wr_addr;

  assign wr_addr = ADDR_W'(load_req.row[IDX_W-1:0]) * ADDR_W'(MAX_DIM)
                 + ADDR_W'(load_req.col[IDX_W-1:0]);

  always_ff @(posedge clk) begin
    if (load_req.we_a) begin
      mem_a[wr_addr] <= load_req.data;
    end
    if (load_req.we_b) begin
      mem_b[wr_addr] <= load_req.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem_a[rd_addr_a];
      rd_data_b <= mem_b[rd_addr_b];
    end
  end

endmodule

[hdl/mme_seq.sv]
// Configuration registers, input decode and the row/column/inner-step sequencer.
module mme_seq import mme_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [CFG_IDX_W-1:0]                cfg_index,
  input  logic [CFG_W-1:0]                    cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [IN_TDATA_W-1:0]               in_data,
  input  logic                                advance,
  output load_req_t                           load_req,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  rd_addr_a,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  rd_addr_b,
  output logic                                step_valid,
  output step_ctrl_t                          step
);

  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int DIM_W  = IDX_W + 1;
  localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t state;

  logic [CFG_W-1:0] rows_a;
  logic [CFG_W-1:0] inner_dim;
  logic [CFG_W-1:0] cols_b;

  logic [DIM_W-1:0] nr, nk, nc;
  logic [DIM_W-1:0] nr_eff, nk_eff, nc_eff;
  logic [IDX_W-1:0] i, j, k;
  logic             i_end, j_end, k_end;

  logic [OPCODE_W-1:0] opcode;
  logic [COORD_W-1:0]  row_index;
  logic [COORD_W-1:0]  col_index;
  logic [DATA_W-1:0]   element_value;
  logic                in_fire;
  logic                in_range;

  assign opcode        = in_data[1:0];
  assign row_index     = in_data[4:2];
  assign col_index     = in_data[7:5];
  assign element_value = in_data[23:8];

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign in_range = (32'(row_index) < 32'(MAX_DIM)) && (32'(col_index) < 32'(MAX_DIM));

  always_comb begin
    load_req.we_a = in_fire && (opcode == OP_LOAD_A) && in_range;
    load_req.we_b = in_fire && (opcode == OP_LOAD_B) && in_range;
    load_req.row  = row_index;
    load_req.col  = col_index;
    load_req.data = element_value;
  end

  // Register values above the store size count as the store size.
  assign nr_eff = (rows_a > CFG_W'(MAX_DIM))    ? DIM_W'(MAX_DIM) : DIM_W'(rows_a);
  assign nk_eff = (inner_dim > CFG_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(inner_dim);
  assign nc_eff = (cols_b > CFG_W'(MAX_DIM))    ? DIM_W'(MAX_DIM) : DIM_W'(cols_b);

  // An inner dimension of zero still takes one step per element, with a zero product.
  assign k_end = (nk == '0) || ((DIM_W'(k) + DIM_W'(1)) == nk);
  assign j_end = (DIM_W'(j) + DIM_W'(1)) == nc;
  assign i_end = (DIM_W'(i) + DIM_W'(1)) == nr;

  assign rd_addr_a = ADDR_W'(i) * ADDR_W'(MAX_DIM) + ADDR_W'(k);
  assign rd_addr_b = ADDR_W'(k) * ADDR_W'(MAX_DIM) + ADDR_W'(j);

  assign step_valid = (state == ST_RUN);

  always_comb begin
    step.row       = COORD_W'(i);
    step.col       = COORD_W'(j);
    step.first     = (k == '0);
    step.last      = k_end;
    step.zero      = (nk == '0);
    step.last_elem = i_end && j_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rows_a    <= ROWS_A_RESET;
      inner_dim <= INNER_DIM_RESET;
      cols_b    <= COLS_B_RESET;
      nr        <= '0;
      nk        <= '0;
      nc        <= '0;
      i         <= '0;
      j         <= '0;
      k         <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ROWS_A:    rows_a    <= cfg_data;
          REG_INNER_DIM: inner_dim <= cfg_data;
          REG_COLS_B:    cols_b    <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire && (opcode == OP_COMPUTE) && (nr_eff != '0) && (nc_eff != '0)) begin
            state <= ST_RUN;
            nr    <= nr_eff;
            nk    <= nk_eff;
            nc    <= nc_eff;
            i     <= '0;
            j     <= '0;
            k     <= '0;
          end
        end
        ST_RUN: begin
          if (advance) begin
            if (!k_end) begin
              k <= k + IDX_W'(1);
            end else begin
              k <= '0;
              if (!j_end) begin
                j <= j + IDX_W'(1);
              end else begin
                j <= '0;
                if (!i_end) begin
                  i <= i + IDX_W'(1);
                end else begin
                  i     <= '0;
                  state <= ST_IDLE;
                end
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[hdl/mme_mac.sv]
// Multiply-accumulate pipeline and the output register of the result stream.
module mme_mac import mme_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step_valid,
  input  step_ctrl_t             step,
  input  logic [DATA_W-1:0]      rd_data_a,
  input  logic [DATA_W-1:0]      rd_data_b,
  output logic                   advance,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_TDATA_W-1:0] out_data,
  output logic                   out_last
);

  logic                     v1, v2;
  step_ctrl_t               ctrl1, ctrl2;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  sum;

  // The whole pipeline moves only when the output register can take a result.
  assign advance = !out_valid || out_ready;

  assign sum = (ctrl2.first ? ACC_W'(0) : acc) + ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= step_valid;
      v2        <= v1;
      out_valid <= v2 && ctrl2.last;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ctrl1 <= step;
      ctrl2 <= ctrl1;
      prod  <= ctrl1.zero ? PROD_W'(0) : $signed(rd_data_a) * $signed(rd_data_b);
      if (v2) begin
        acc <= sum;
      end
      if (v2 && ctrl2.last) begin
        out_data <= {2'b00, sum, ctrl2.col, ctrl2.row};
        out_last <= ctrl2.last_elem;
      end
    end
  end

endmodule

[hdl/matrix_multiply_engine.sv]
// Matrix multiply engine: loads are accepted one per cycle while no compute is running.
// A compute transaction occupies the input until its last step, with one read of each
// operand store per cycle while the output does not stall; each result passes from the
// last store read of its element through the product register to the output register;
// output stalls hold the whole pipeline.
// Reset (synchronous, active high) clears control and restores the dimension
// registers to 2, 3, 2; the operand stores keep undefined contents until loaded.
module matrix_multiply_engine import mme_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // opcode, row_index, col_index, element_value
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // out_row, out_col, product_value, zero pad
  output logic                   m_axis_tlast
);

  localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);

  load_req_t         load_req;
  logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
  logic [DATA_W-1:0] rd_data_a, rd_data_b;
  logic              step_valid;
  step_ctrl_t        step;
  logic              advance;

  mme_seq #(.MAX_DIM(MAX_DIM)) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_data    (s_axis_tdata),
    .advance    (advance),
    .load_req   (load_req),
    .rd_addr_a  (rd_addr_a),
    .rd_addr_b  (rd_addr_b),
    .step_valid (step_valid),
    .step       (step)
  );

  mme_store #(.MAX_DIM(MAX_DIM)) u_store (
    .clk       (clk),
    .load_req  (load_req),
    .rd_en     (advance),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  mme_mac u_mac (
    .clk        (clk),
    .rst        (rst),
    .step_valid (step_valid),
    .step       (step),
    .rd_data_a  (rd_data_a),
    .rd_data_b  (rd_data_b),
    .advance    (advance),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata),
    .out_last   (m_axis_tlast)
  );

endmodule

[hdl/mme_checker.sv]
// Port-level checker for the matrix multiply engine and its bind.
module mme_checker import mme_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tlast
);

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // Reset leaves the input open and the output empty.
  a_reset_state: assert property (@(posedge clk)
    rst |=> s_axis_tready && !m_axis_tvalid)
    else $error("wrong state after reset");

  // Only a compute transaction closes the input.
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $fell(s_axis_tready) |->
      $past(s_axis_tvalid) && $past(s_axis_tdata[1:0] == OP_COMPUTE))
    else $error("input closed without a compute transaction");

  // Loads never hold off the next transaction.
  a_load_no_block: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tdata[1:0] != OP_COMPUTE) |=> s_axis_tready)
    else $error("input closed after a load");

endmodule

bind matrix_multiply_engine mme_checker u_mme_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
